// File: hdl/sdoc_pkg.sv
// ----------------------------------------------------------------------------
// sdoc_pkg
// Types, codes and constants shared by the expedited transfer client.
// ----------------------------------------------------------------------------
package sdoc_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned NODE_W     = 7;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned SUBIDX_W   = 8;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned SIZE_W     = 3;
  localparam int unsigned RX_ID_W    = 29;
  localparam int unsigned FRAME_W    = 64;
  localparam int unsigned TX_ID_W    = 11;
  localparam int unsigned OUTCOME_W  = 3;
  localparam int unsigned RD_LEN_W   = 3;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned ATTEMPT_W  = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FRAME = 2'd2,
    CMD_TICK  = 2'd3
  } sdoc_cmd_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUTC_SUCCESS     = 3'd0,
    OUTC_ABORT       = 3'd1,
    OUTC_TIMEOUT     = 3'd2,
    OUTC_BAD_SIZE    = 3'd3,
    OUTC_UNSUPPORTED = 3'd4
  } sdoc_outcome_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPTS = 1'b1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd1000;
  localparam logic [ATTEMPT_W-1:0] ATTEMPTS_RST = 8'd3;

  // request command bytes
  localparam logic [7:0] CS_WRITE_1 = 8'h2F;
  localparam logic [7:0] CS_WRITE_2 = 8'h2B;
  localparam logic [7:0] CS_WRITE_4 = 8'h23;
  localparam logic [7:0] CS_READ    = 8'h40;
  // response command bytes
  localparam logic [7:0] RS_READ_4  = 8'h43;
  localparam logic [7:0] RS_READ_2  = 8'h4B;
  localparam logic [7:0] RS_READ_1  = 8'h4F;
  localparam logic [7:0] RS_WRITE   = 8'h60;
  localparam logic [7:0] RS_ABORT   = 8'h80;

  localparam logic [TX_ID_W-1:0] TX_ID_BASE = 11'h600;
  localparam logic [RX_ID_W-1:0] RX_ID_BASE = 29'h580;

  localparam logic [SIZE_W-1:0] SIZE_1 = 3'd1;
  localparam logic [SIZE_W-1:0] SIZE_2 = 3'd2;
  localparam logic [SIZE_W-1:0] SIZE_4 = 3'd4;

  localparam logic [RD_LEN_W-1:0] RD_LEN_1 = 3'd1;
  localparam logic [RD_LEN_W-1:0] RD_LEN_2 = 3'd2;
  localparam logic [RD_LEN_W-1:0] RD_LEN_4 = 3'd4;

  typedef struct packed {
    sdoc_cmd_t             command;
    logic [NODE_W-1:0]     node_id;
    logic [INDEX_W-1:0]    object_index;
    logic [SUBIDX_W-1:0]   object_subindex;
    logic [VALUE_W-1:0]    write_value;
    logic [SIZE_W-1:0]     write_size;
    logic [RX_ID_W-1:0]    rx_identifier;
    logic                  rx_extended;
    logic [FRAME_W-1:0]    rx_payload;
  } sdoc_item_t;

  typedef struct packed {
    logic                  tx_valid;
    logic [TX_ID_W-1:0]    tx_identifier;
    logic [FRAME_W-1:0]    tx_payload;
    logic                  done_res;
    sdoc_outcome_t         outcome;
    logic [RD_LEN_W-1:0]   read_length;
    logic [VALUE_W-1:0]    read_value;
  } sdoc_result_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0]  response_timeout_ms;
    logic [ATTEMPT_W-1:0]  attempt_limit;
  } sdoc_cfg_t;

endpackage

// File: hdl/sdoc_chan_if.sv
// ----------------------------------------------------------------------------
// sdoc channel interfaces
// Valid/ready channels for request/event beats and for result beats.
// ----------------------------------------------------------------------------
interface sdoc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [sdoc_pkg::CMD_W-1:0]           command;
  logic [sdoc_pkg::NODE_W-1:0]          node_id;
  logic [sdoc_pkg::INDEX_W-1:0]         object_index;
  logic [sdoc_pkg::SUBIDX_W-1:0]        object_subindex;
  logic [sdoc_pkg::VALUE_W-1:0]         write_value;
  logic [sdoc_pkg::SIZE_W-1:0]          write_size;
  logic [sdoc_pkg::RX_ID_W-1:0]         rx_identifier;
  logic                                 rx_extended;
  logic [sdoc_pkg::FRAME_W-1:0]         rx_payload;

  modport source (
    output valid, command, node_id, object_index, object_subindex,
           write_value, write_size, rx_identifier, rx_extended, rx_payload,
    input  ready
  );
  modport sink (
    input  valid, command, node_id, object_index, object_subindex,
           write_value, write_size, rx_identifier, rx_extended, rx_payload,
    output ready
  );
endinterface

interface sdoc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 tx_valid;
  logic [sdoc_pkg::TX_ID_W-1:0]         tx_identifier;
  logic [sdoc_pkg::FRAME_W-1:0]         tx_payload;
  logic                                 done_res;
  logic [sdoc_pkg::OUTCOME_W-1:0]       outcome;
  logic [sdoc_pkg::RD_LEN_W-1:0]        read_length;
  logic [sdoc_pkg::VALUE_W-1:0]         read_value;

  modport source (
    output valid, tx_valid, tx_identifier, tx_payload, done_res, outcome,
           read_length, read_value,
    input  ready
  );
  modport sink (
    input  valid, tx_valid, tx_identifier, tx_payload, done_res, outcome,
           read_length, read_value,
    output ready
  );
endinterface

// File: hdl/sdo_expedited_client_unit.sv
// ----------------------------------------------------------------------------
// sdo_expedited_client_unit
// Client for expedited object-dictionary reads and writes over the bus.
// ----------------------------------------------------------------------------
// Takes one beat per cycle (requests, received frames and millisecond ticks)
// and returns exactly one result beat for each: the beat is held in the input
// register, then makes one pass through the transfer logic into the result
// register. The throughput of one beat per clock is set by that
// single registered pass, which also updates the transfer state; a stalled
// result register holds the input side only once both registers are full.
// Configuration writes take effect on the next cycle and are meant for idle.
module sdo_expedited_client_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  sdoc_in_if.sink                         in_ch,
  sdoc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [sdoc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdoc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  sdoc_pkg::sdoc_cfg_t    cfg;
  sdoc_pkg::sdoc_item_t   item_r;
  sdoc_pkg::sdoc_item_t   in_item;
  sdoc_pkg::sdoc_result_t res;
  sdoc_pkg::sdoc_result_t res_r;
  logic                   item_vld_r;
  logic                   out_vld_r;
  logic                   step;
  logic                   in_beat;

  assign in_item.command         = sdoc_pkg::sdoc_cmd_t'(in_ch.command);
  assign in_item.node_id         = in_ch.node_id;
  assign in_item.object_index    = in_ch.object_index;
  assign in_item.object_subindex = in_ch.object_subindex;
  assign in_item.write_value     = in_ch.write_value;
  assign in_item.write_size      = in_ch.write_size;
  assign in_item.rx_identifier   = in_ch.rx_identifier;
  assign in_item.rx_extended     = in_ch.rx_extended;
  assign in_item.rx_payload      = in_ch.rx_payload;

  // item moves into the result register
  assign step        = item_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !item_vld_r || step;
  assign in_beat     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_beat) begin
        item_vld_r <= 1'b1;
      end else if (step) begin
        item_vld_r <= 1'b0;
      end
      if (step) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      item_r <= in_item;
    end
    if (step) begin
      res_r <= res;
    end
  end

  sdoc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sdoc_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_ch.valid         = out_vld_r;
  assign out_ch.tx_valid      = res_r.tx_valid;
  assign out_ch.tx_identifier = res_r.tx_identifier;
  assign out_ch.tx_payload    = res_r.tx_payload;
  assign out_ch.done_res      = res_r.done_res;
  assign out_ch.outcome       = res_r.outcome;
  assign out_ch.read_length   = res_r.read_length;
  assign out_ch.read_value    = res_r.read_value;

endmodule

// File: hdl/sdoc_cfg_regs.sv
// ----------------------------------------------------------------------------
// sdoc_cfg_regs
// Response timeout and attempt limit registers behind a plain write port.
// ----------------------------------------------------------------------------
module sdoc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sdoc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdoc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output sdoc_pkg::sdoc_cfg_t                 cfg
);

  sdoc_pkg::sdoc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.response_timeout_ms <= sdoc_pkg::TIMEOUT_RST;
      cfg_r.attempt_limit       <= sdoc_pkg::ATTEMPTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdoc_pkg::CFG_TIMEOUT: begin
          cfg_r.response_timeout_ms <= cfg_wdata[sdoc_pkg::TIMEOUT_W-1:0];
        end
        sdoc_pkg::CFG_ATTEMPTS: begin
          cfg_r.attempt_limit <= cfg_wdata[sdoc_pkg::ATTEMPT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/sdoc_engine.sv
// ----------------------------------------------------------------------------
// sdoc_engine
// Transfer state and the single-pass logic that turns one beat into one
// result: request framing, response decode, tick countdown and resend.
// ----------------------------------------------------------------------------
module sdoc_engine (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  sdoc_pkg::sdoc_item_t    item,
  input  sdoc_pkg::sdoc_cfg_t     cfg,
  output sdoc_pkg::sdoc_result_t  res
);

  logic                               busy_r, busy_nxt;
  logic                               is_read_r, is_read_nxt;
  logic [sdoc_pkg::NODE_W-1:0]        node_r, node_nxt;
  logic [sdoc_pkg::FRAME_W-1:0]       frame_r, frame_nxt;
  logic [sdoc_pkg::TIMEOUT_W-1:0]     wait_r, wait_nxt;
  logic [sdoc_pkg::ATTEMPT_W-1:0]     attempts_r, attempts_nxt;

  logic [7:0]                         req_cs;
  logic                               size_ok;
  logic [7:0]                         rsp_cs;
  logic [sdoc_pkg::VALUE_W-1:0]       rsp_data;
  logic                               rsp_match;
  logic                               do_send;

  assign rsp_cs    = item.rx_payload[7:0];
  assign rsp_data  = item.rx_payload[63:32];
  assign rsp_match = !item.rx_extended &&
                     (item.rx_identifier ==
                      (sdoc_pkg::RX_ID_BASE +
                       {{(sdoc_pkg::RX_ID_W-sdoc_pkg::NODE_W){1'b0}}, node_r}));

  always_comb begin
    size_ok = 1'b1;
    req_cs  = sdoc_pkg::CS_READ;
    if (item.command == sdoc_pkg::CMD_WRITE) begin
      priority if (item.write_size == sdoc_pkg::SIZE_1) begin
        req_cs = sdoc_pkg::CS_WRITE_1;
      end else if (item.write_size == sdoc_pkg::SIZE_2) begin
        req_cs = sdoc_pkg::CS_WRITE_2;
      end else if (item.write_size == sdoc_pkg::SIZE_4) begin
        req_cs = sdoc_pkg::CS_WRITE_4;
      end else begin
        size_ok = 1'b0;
      end
    end
  end

  always_comb begin
    busy_nxt     = busy_r;
    is_read_nxt  = is_read_r;
    node_nxt     = node_r;
    frame_nxt    = frame_r;
    wait_nxt     = wait_r;
    attempts_nxt = attempts_r;
    do_send      = 1'b0;
    res          = '0;

    unique case (item.command)
      sdoc_pkg::CMD_WRITE, sdoc_pkg::CMD_READ: begin
        if (!busy_r) begin
          if (!size_ok) begin
            res.done_res = 1'b1;
            res.outcome  = sdoc_pkg::OUTC_BAD_SIZE;
          end else if (cfg.attempt_limit == '0) begin
            res.done_res = 1'b1;
            res.outcome  = sdoc_pkg::OUTC_TIMEOUT;
          end else begin
            busy_nxt     = 1'b1;
            is_read_nxt  = (item.command == sdoc_pkg::CMD_READ);
            node_nxt     = item.node_id;
            frame_nxt    = {(item.command == sdoc_pkg::CMD_READ) ?
                            {sdoc_pkg::VALUE_W{1'b0}} : item.write_value,
                            item.object_subindex, item.object_index, req_cs};
            attempts_nxt = cfg.attempt_limit - 1'b1;
            do_send      = 1'b1;
          end
        end
      end
      sdoc_pkg::CMD_FRAME: begin
        if (busy_r && rsp_match) begin
          if (!is_read_r) begin
            if (rsp_cs == sdoc_pkg::RS_WRITE) begin
              res.done_res = 1'b1;
              res.outcome  = sdoc_pkg::OUTC_SUCCESS;
            end else if (rsp_cs == sdoc_pkg::RS_ABORT) begin
              res.done_res = 1'b1;
              res.outcome  = sdoc_pkg::OUTC_ABORT;
            end
          end else begin
            res.done_res = 1'b1;
            unique case (rsp_cs)
              sdoc_pkg::RS_READ_4: begin
                res.outcome     = sdoc_pkg::OUTC_SUCCESS;
                res.read_length = sdoc_pkg::RD_LEN_4;
                res.read_value  = rsp_data;
              end
              sdoc_pkg::RS_READ_2: begin
                res.outcome     = sdoc_pkg::OUTC_SUCCESS;
                res.read_length = sdoc_pkg::RD_LEN_2;
                res.read_value  = {16'b0, rsp_data[15:0]};
              end
              sdoc_pkg::RS_READ_1: begin
                res.outcome     = sdoc_pkg::OUTC_SUCCESS;
                res.read_length = sdoc_pkg::RD_LEN_1;
                res.read_value  = {24'b0, rsp_data[7:0]};
              end
              sdoc_pkg::RS_ABORT: begin
                res.outcome = sdoc_pkg::OUTC_ABORT;
              end
              default: begin
                res.outcome = sdoc_pkg::OUTC_UNSUPPORTED;
              end
            endcase
          end
          if (res.done_res) begin
            busy_nxt = 1'b0;
          end
        end
      end
      sdoc_pkg::CMD_TICK: begin
        if (busy_r) begin
          if (wait_r > 16'd1) begin
            wait_nxt = wait_r - 1'b1;
          end else begin
            wait_nxt = '0;
            if (attempts_r != '0) begin
              attempts_nxt = attempts_r - 1'b1;
              do_send      = 1'b1;
            end else begin
              busy_nxt     = 1'b0;
              res.done_res = 1'b1;
              res.outcome  = sdoc_pkg::OUTC_TIMEOUT;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (do_send) begin
      res.tx_valid      = 1'b1;
      res.tx_identifier = sdoc_pkg::TX_ID_BASE +
                          {{(sdoc_pkg::TX_ID_W-sdoc_pkg::NODE_W){1'b0}}, node_nxt};
      res.tx_payload    = frame_nxt;
      wait_nxt          = cfg.response_timeout_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (step) begin
      busy_r <= busy_nxt;
    end
  end

  // only meaningful while busy
  always_ff @(posedge clk) begin
    if (step) begin
      is_read_r  <= is_read_nxt;
      node_r     <= node_nxt;
      frame_r    <= frame_nxt;
      wait_r     <= wait_nxt;
      attempts_r <= attempts_nxt;
    end
  end

endmodule

// File: hdl/sdoc_checker.sv
// ----------------------------------------------------------------------------
// sdoc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sdoc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            tx_valid,
  input logic [sdoc_pkg::TX_ID_W-1:0]    tx_identifier,
  input logic [sdoc_pkg::FRAME_W-1:0]    tx_payload,
  input logic                            done_res,
  input logic [sdoc_pkg::OUTCOME_W-1:0]  outcome,
  input logic [sdoc_pkg::RD_LEN_W-1:0]   read_length
);

  // a pending result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_no_outcome_unless_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !done_res |-> outcome == '0 && read_length == '0)
    else $error("outcome or read length set without completion");

  // request ids live in 0x600..0x67f
  a_tx_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tx_valid |-> tx_identifier[10:7] == 4'hC)
    else $error("request frame id out of range");

  a_tx_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !tx_valid |-> tx_identifier == '0 && tx_payload == '0)
    else $error("frame fields set without a send");

  a_read_len_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && read_length != '0 |->
      done_res && outcome == sdoc_pkg::OUTC_SUCCESS && !tx_valid)
    else $error("read data without a successful finish");

endmodule

bind sdo_expedited_client_unit sdoc_checker u_sdoc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .tx_valid      (out_ch.tx_valid),
  .tx_identifier (out_ch.tx_identifier),
  .tx_payload    (out_ch.tx_payload),
  .done_res      (out_ch.done_res),
  .outcome       (out_ch.outcome),
  .read_length   (out_ch.read_length)
);
